// ----- hdl/cable_net_node_relax_update_top_defines.svh -----
// assertion macros shared by the relaxation update modules
`ifndef CABLE_NET_NODE_RELAX_UPDATE_TOP_DEFINES_SVH
`define CABLE_NET_NODE_RELAX_UPDATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CNR_ASSERT_IMP(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("cable net node update check failed");
`define CNR_ASSERT_NXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("cable net node update check failed");
`else
`define CNR_ASSERT_IMP(name, clock, resetn, ante, cons)
`define CNR_ASSERT_NXT(name, clock, resetn, ante, cons)
`endif

`endif

// ----- hdl/cnr_pkg.sv -----
package cnr_pkg;

    // pipeline geometry
    localparam int unsigned RootSteps = 32;
    localparam int unsigned QuotBits  = 33;
    localparam int unsigned DivLanes  = 6;
    localparam int unsigned Axes      = 3;

    // node classes
    localparam logic [2:0] CLS_REMOVED = 3'd0;
    localparam logic [2:0] CLS_FREE    = 3'd1;
    localparam logic [2:0] CLS_RIM     = 3'd2;
    localparam logic [2:0] CLS_SLIDE_X = 3'd3;
    localparam logic [2:0] CLS_SLIDE_Y = 3'd4;
    localparam logic [2:0] CLS_HELD    = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_CIRCLE_RADIUS = 2'd0;
    localparam logic [1:0] CFG_RIM_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_DAMPING       = 2'd2;
    localparam logic [1:0] CFG_MOVEMENT_GAIN = 2'd3;

    // divider lanes
    localparam int unsigned LANE_FX = 0;
    localparam int unsigned LANE_FY = 1;
    localparam int unsigned LANE_VX = 2;
    localparam int unsigned LANE_VY = 3;
    localparam int unsigned LANE_PX = 4;
    localparam int unsigned LANE_PY = 5;

    typedef struct packed {
        logic [2:0]         node_class;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } node_in_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
    } node_out_t;

    typedef struct packed {
        logic [30:0]        circle_radius;
        logic signed [31:0] rim_height;
        logic [15:0]        damping;
        logic [15:0]        movement_gain;
    } cfg_t;

    typedef struct packed {
        node_in_t    node;
        logic [63:0] r2;
        logic [63:0] mag_f;
        logic        neg_f;
        logic [63:0] mag_v;
        logic        neg_v;
        logic [31:0] root;
    } node_ctx_t;

    typedef logic [DivLanes-1:0][QuotBits-1:0] quot_set_t;

    typedef struct packed {
        logic               move;
        logic signed [31:0] pos;
        logic signed [34:0] vel;
        logic signed [34:0] frc;
    } axis_t;

    // magnitude of a signed 32-bit value
    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

endpackage

// ----- hdl/cnr_front.sv -----
module cnr_front
    import cnr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  node_in_t  item,
    output logic      ctx_vld,
    output node_ctx_t ctx
);

    logic      in_vld_reg;
    node_in_t  in_reg;
    logic      mul_vld_reg;
    node_in_t  mul_node_reg;
    logic [63:0] sqx_reg;
    logic [63:0] sqy_reg;
    logic signed [63:0] dfx_reg;
    logic signed [63:0] dfy_reg;
    logic signed [63:0] dvx_reg;
    logic signed [63:0] dvy_reg;
    logic      sum_vld_reg;
    node_ctx_t ctx_reg;

    logic [31:0] abs_x;
    logic [31:0] abs_y;
    logic [63:0] sqx_next;
    logic [63:0] sqy_next;
    logic signed [63:0] dfx_next;
    logic signed [63:0] dfy_next;
    logic signed [63:0] dvx_next;
    logic signed [63:0] dvy_next;
    logic signed [64:0] dot_f;
    logic signed [64:0] dot_v;
    node_ctx_t ctx_next;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= accept;
            mul_vld_reg <= in_vld_reg;
            sum_vld_reg <= mul_vld_reg;
        end
    end

    // squares of the planar position and products for the two dot products
    assign abs_x    = abs32(in_reg.pos_x);
    assign abs_y    = abs32(in_reg.pos_y);
    assign sqx_next = 64'(abs_x) * 64'(abs_x);
    assign sqy_next = 64'(abs_y) * 64'(abs_y);
    assign dfx_next = 64'($signed(in_reg.pos_x)) * 64'($signed(in_reg.force_x));
    assign dfy_next = 64'($signed(in_reg.pos_y)) * 64'($signed(in_reg.force_y));
    assign dvx_next = 64'($signed(in_reg.pos_x)) * 64'($signed(in_reg.vel_x));
    assign dvy_next = 64'($signed(in_reg.pos_y)) * 64'($signed(in_reg.vel_y));

    // radius squared and dot product magnitude and sign
    assign dot_f = 65'(dfx_reg) + 65'(dfy_reg);
    assign dot_v = 65'(dvx_reg) + 65'(dvy_reg);

    always_comb
    begin
        ctx_next       = '0;
        ctx_next.node  = mul_node_reg;
        ctx_next.r2    = sqx_reg + sqy_reg;
        ctx_next.mag_f = dot_f[64] ? 64'(-dot_f) : dot_f[63:0];
        ctx_next.neg_f = dot_f[64];
        ctx_next.mag_v = dot_v[64] ? 64'(-dot_v) : dot_v[63:0];
        ctx_next.neg_v = dot_v[64];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_reg       <= item;
        mul_node_reg <= in_reg;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        dfx_reg      <= dfx_next;
        dfy_reg      <= dfy_next;
        dvx_reg      <= dvx_next;
        dvy_reg      <= dvy_next;
        ctx_reg      <= ctx_next;
    end

    assign ctx_vld = sum_vld_reg;
    assign ctx     = ctx_reg;

endmodule

// ----- hdl/cnr_isqrt.sv -----
`include "cable_net_node_relax_update_top_defines.svh"

module cnr_isqrt
    import cnr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      vld_in,
    input  node_ctx_t ctx_in,
    output logic      vld_out,
    output node_ctx_t ctx_out
);

    logic        vld_reg [RootSteps];
    node_ctx_t   ctx_reg [RootSteps];
    logic [63:0] rem_reg [RootSteps];
    logic [63:0] res_reg [RootSteps];

    // one result bit per stage, most significant first
    for (genvar k = 0; k < RootSteps; k++)
    begin : g_step
        localparam logic [63:0] StepBit = 64'd1 << (2 * (RootSteps - 1 - k));
        logic        vld_prev;
        node_ctx_t   ctx_prev;
        logic [63:0] rem_prev;
        logic [63:0] res_prev;
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [63:0] res_next;

        if (k == 0)
        begin : g_first
            assign vld_prev = vld_in;
            assign ctx_prev = ctx_in;
            assign rem_prev = ctx_in.r2;
            assign res_prev = '0;
        end
        else
        begin : g_rest
            assign vld_prev = vld_reg[k-1];
            assign ctx_prev = ctx_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign res_prev = res_reg[k-1];
        end

        assign trial = res_prev + StepBit;

        always_comb
        begin
            if (rem_prev >= trial)
            begin
                rem_next = rem_prev - trial;
                res_next = (res_prev >> 1) + StepBit;
            end
            else
            begin
                rem_next = rem_prev;
                res_next = res_prev >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            ctx_reg[k] <= ctx_prev;
            rem_reg[k] <= rem_next;
            res_reg[k] <= res_next;
        end
    end

    // root joins the context
    always_comb
    begin
        ctx_out      = ctx_reg[RootSteps-1];
        ctx_out.root = res_reg[RootSteps-1][31:0];
    end

    assign vld_out = vld_reg[RootSteps-1];

    `CNR_ASSERT_IMP(a_root_floor, clk, rst_n, vld_out, (64'(ctx_out.root) * 64'(ctx_out.root) <= ctx_out.r2) && ((66'(ctx_out.root) + 66'd1) * (66'(ctx_out.root) + 66'd1) > 66'(ctx_out.r2)))

endmodule

// ----- hdl/cnr_divide.sv -----
`include "cable_net_node_relax_update_top_defines.svh"

module cnr_divide
    import cnr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      vld_in,
    input  node_ctx_t ctx_in,
    output logic      vld_out,
    output node_ctx_t ctx_out,
    output quot_set_t quot
);

    logic        m1_vld_reg;
    node_ctx_t   m1_ctx_reg;
    logic [63:0] lo_reg [DivLanes];
    logic [63:0] hi_reg [DivLanes];
    logic        m2_vld_reg;
    node_ctx_t   m2_ctx_reg;
    logic [95:0] num_reg [DivLanes];

    logic                dv_vld_reg [QuotBits];
    node_ctx_t           dv_ctx_reg [QuotBits];
    logic [63:0]         rem_reg [QuotBits][DivLanes];
    logic [QuotBits-1:0] lq_reg  [QuotBits][DivLanes];

    logic [31:0] abs_x;
    logic [31:0] abs_y;
    logic [31:0] mul_p [DivLanes];
    logic [63:0] mul_m [DivLanes];

    // multiplier operands per lane
    assign abs_x = abs32(ctx_in.node.pos_x);
    assign abs_y = abs32(ctx_in.node.pos_y);
    assign mul_p[LANE_FX] = abs_x;
    assign mul_m[LANE_FX] = ctx_in.mag_f;
    assign mul_p[LANE_FY] = abs_y;
    assign mul_m[LANE_FY] = ctx_in.mag_f;
    assign mul_p[LANE_VX] = abs_x;
    assign mul_m[LANE_VX] = ctx_in.mag_v;
    assign mul_p[LANE_VY] = abs_y;
    assign mul_m[LANE_VY] = ctx_in.mag_v;
    assign mul_p[LANE_PX] = abs_x;
    assign mul_m[LANE_PX] = 64'(cfg.circle_radius);
    assign mul_p[LANE_PY] = abs_y;
    assign mul_m[LANE_PY] = 64'(cfg.circle_radius);

    // valid for the two product stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= vld_in;
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_ctx_reg <= ctx_in;
        m2_ctx_reg <= m1_ctx_reg;
    end

    // numerator as two 32x32 partial products, then summed
    for (genvar l = 0; l < DivLanes; l++)
    begin : g_prod
        logic [63:0] lo_next;
        logic [63:0] hi_next;
        logic [95:0] num_next;

        assign lo_next  = 64'(mul_m[l][31:0]) * 64'(mul_p[l]);
        assign hi_next  = 64'(mul_m[l][63:32]) * 64'(mul_p[l]);
        assign num_next = 96'(lo_reg[l]) + {hi_reg[l], 32'd0};

        always_ff @(posedge clk)
        begin
            lo_reg[l]  <= lo_next;
            hi_reg[l]  <= hi_next;
            num_reg[l] <= num_next;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QuotBits; j++)
    begin : g_step
        logic      vld_prev;
        node_ctx_t ctx_prev;

        if (j == 0)
        begin : g_first
            assign vld_prev = m2_vld_reg;
            assign ctx_prev = m2_ctx_reg;
        end
        else
        begin : g_rest
            assign vld_prev = dv_vld_reg[j-1];
            assign ctx_prev = dv_ctx_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_ctx_reg[j] <= ctx_prev;
        end

        for (genvar l = 0; l < DivLanes; l++)
        begin : g_lane
            logic [63:0]         den;
            logic [63:0]         rem_prev;
            logic [QuotBits-1:0] lq_prev;
            logic [64:0]         trial;
            logic                ge;
            logic [64:0]         diff;
            logic [63:0]         rem_next;
            logic [QuotBits-1:0] lq_next;

            if (l < LANE_PX)
            begin : g_r2
                assign den = ctx_prev.r2;
            end
            else
            begin : g_root
                assign den = 64'(ctx_prev.root);
            end

            if (j == 0)
            begin : g_first
                assign rem_prev = 64'(num_reg[l][95:QuotBits]);
                assign lq_prev  = num_reg[l][QuotBits-1:0];
            end
            else
            begin : g_rest
                assign rem_prev = rem_reg[j-1][l];
                assign lq_prev  = lq_reg[j-1][l];
            end

            assign trial    = {rem_prev, lq_prev[QuotBits-1]};
            assign ge       = trial >= 65'(den);
            assign diff     = trial - 65'(den);
            assign rem_next = ge ? diff[63:0] : trial[63:0];
            assign lq_next  = {lq_prev[QuotBits-2:0], ge};

            always_ff @(posedge clk)
            begin
                rem_reg[j][l] <= rem_next;
                lq_reg[j][l]  <= lq_next;
            end
        end
    end

    // quotients out
    for (genvar l = 0; l < DivLanes; l++)
    begin : g_out
        assign quot[l] = lq_reg[QuotBits-1][l];
    end

    assign vld_out = dv_vld_reg[QuotBits-1];
    assign ctx_out = dv_ctx_reg[QuotBits-1];

    `CNR_ASSERT_IMP(a_rem_below_r2, clk, rst_n, vld_out && (ctx_out.node.node_class == CLS_RIM) && (ctx_out.r2 != 64'd0), rem_reg[QuotBits-1][LANE_FX] < ctx_out.r2)

endmodule

// ----- hdl/cnr_back.sv -----
`include "cable_net_node_relax_update_top_defines.svh"

module cnr_back
    import cnr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      ctx_vld,
    input  node_ctx_t ctx,
    input  quot_set_t quot,
    output logic      done,
    output node_out_t result
);

    localparam logic signed [37:0] VelMax = 38'sd2147483647;
    localparam logic signed [37:0] VelMin = -38'sd2147483648;
    localparam logic signed [32:0] PosMax = 33'sd2147483647;
    localparam logic signed [32:0] PosMin = -33'sd2147483648;

    logic               b1_vld_reg;
    axis_t              b1_ax_reg [Axes];
    logic               b2_vld_reg;
    logic               b2_move_reg [Axes];
    logic signed [31:0] b2_pin_reg [Axes];
    logic signed [31:0] b2_vin_reg [Axes];
    logic signed [51:0] b2_dv_reg [Axes];
    logic signed [51:0] b2_gf_reg [Axes];
    logic               b3_vld_reg;
    logic               b3_move_reg [Axes];
    logic signed [31:0] b3_pin_reg [Axes];
    logic signed [31:0] b3_vel_reg [Axes];
    logic               done_reg;
    logic signed [31:0] pos_out_reg [Axes];
    logic signed [31:0] vel_out_reg [Axes];

    logic               rim_move;
    logic [2:0]         mv;
    logic signed [34:0] fx_rad;
    logic signed [34:0] fy_rad;
    logic signed [34:0] vx_rad;
    logic signed [34:0] vy_rad;
    logic signed [31:0] px_scl;
    logic signed [31:0] py_scl;
    axis_t              b1_ax_next [Axes];

    // signed radial correction from an unsigned quotient
    function automatic logic signed [34:0] corr(input logic [QuotBits-1:0] q,
                                                input logic flip);
        logic signed [34:0] w;
        w = $signed(35'(q));
        return flip ? -w : w;
    endfunction

    function automatic logic signed [34:0] wide(input logic signed [31:0] x);
        return 35'($signed(x));
    endfunction

    // rim geometry: strip radial parts, project onto the circle
    assign rim_move = (ctx.node.node_class == CLS_RIM) && (ctx.r2 != 64'd0);
    assign fx_rad = wide(ctx.node.force_x)
                  - corr(quot[LANE_FX], ctx.neg_f ^ ctx.node.pos_x[31]);
    assign fy_rad = wide(ctx.node.force_y)
                  - corr(quot[LANE_FY], ctx.neg_f ^ ctx.node.pos_y[31]);
    assign vx_rad = wide(ctx.node.vel_x)
                  - corr(quot[LANE_VX], ctx.neg_v ^ ctx.node.pos_x[31]);
    assign vy_rad = wide(ctx.node.vel_y)
                  - corr(quot[LANE_VY], ctx.neg_v ^ ctx.node.pos_y[31]);
    assign px_scl = ctx.node.pos_x[31] ? -$signed(32'(quot[LANE_PX]))
                                       : $signed(32'(quot[LANE_PX]));
    assign py_scl = ctx.node.pos_y[31] ? -$signed(32'(quot[LANE_PY]))
                                       : $signed(32'(quot[LANE_PY]));

    // which axes move for this class
    always_comb
    begin
        mv = 3'b000;
        case (ctx.node.node_class)
            CLS_FREE:              mv = 3'b111;
            CLS_RIM:               mv = rim_move ? 3'b111 : 3'b000;
            CLS_SLIDE_X:           mv = 3'b001;
            CLS_SLIDE_Y:           mv = 3'b010;
            CLS_REMOVED, CLS_HELD: mv = 3'b000;
            default:               mv = 3'b000;
        endcase
    end

    // per-axis operands
    always_comb
    begin
        b1_ax_next[0].move = mv[0];
        b1_ax_next[0].pos  = rim_move ? px_scl : ctx.node.pos_x;
        b1_ax_next[0].vel  = rim_move ? vx_rad : wide(ctx.node.vel_x);
        b1_ax_next[0].frc  = rim_move ? fx_rad : wide(ctx.node.force_x);
        b1_ax_next[1].move = mv[1];
        b1_ax_next[1].pos  = rim_move ? py_scl : ctx.node.pos_y;
        b1_ax_next[1].vel  = rim_move ? vy_rad : wide(ctx.node.vel_y);
        b1_ax_next[1].frc  = rim_move ? fy_rad : wide(ctx.node.force_y);
        b1_ax_next[2].move = mv[2];
        b1_ax_next[2].pos  = rim_move ? cfg.rim_height : ctx.node.pos_z;
        b1_ax_next[2].vel  = rim_move ? '0 : wide(ctx.node.vel_z);
        b1_ax_next[2].frc  = rim_move ? '0 : wide(ctx.node.force_z);
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            b1_vld_reg <= ctx_vld;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
            done_reg   <= b3_vld_reg;
        end
    end

    // damped velocity and position update per axis
    for (genvar k = 0; k < Axes; k++)
    begin : g_axis
        logic signed [51:0] dv_next;
        logic signed [51:0] gf_next;
        logic signed [52:0] sum;
        logic signed [37:0] shr;
        logic signed [31:0] vsat;
        logic signed [31:0] vel_next;
        logic signed [32:0] psum;
        logic signed [31:0] psat;
        logic signed [31:0] pos_next;

        assign dv_next = $signed({1'b0, cfg.damping}) * b1_ax_reg[k].vel;
        assign gf_next = $signed({1'b0, cfg.movement_gain}) * b1_ax_reg[k].frc;

        // round to nearest at bit 15, floor shift, saturate
        assign sum = 53'(b2_dv_reg[k]) + 53'(b2_gf_reg[k]) + 53'sd16384;
        assign shr = 38'(sum >>> 15);

        always_comb
        begin
            if (shr > VelMax)
            begin
                vsat = VelMax[31:0];
            end
            else if (shr < VelMin)
            begin
                vsat = VelMin[31:0];
            end
            else
            begin
                vsat = shr[31:0];
            end
        end

        assign vel_next = b2_move_reg[k] ? vsat : b2_vin_reg[k];

        // position plus new velocity, saturated
        assign psum = 33'(b3_pin_reg[k]) + 33'(b3_vel_reg[k]);

        always_comb
        begin
            if (psum > PosMax)
            begin
                psat = PosMax[31:0];
            end
            else if (psum < PosMin)
            begin
                psat = PosMin[31:0];
            end
            else
            begin
                psat = psum[31:0];
            end
        end

        assign pos_next = b3_move_reg[k] ? psat : b3_pin_reg[k];

        always_ff @(posedge clk)
        begin
            b1_ax_reg[k]   <= b1_ax_next[k];
            b2_move_reg[k] <= b1_ax_reg[k].move;
            b2_pin_reg[k]  <= b1_ax_reg[k].pos;
            b2_vin_reg[k]  <= b1_ax_reg[k].vel[31:0];
            b2_dv_reg[k]   <= dv_next;
            b2_gf_reg[k]   <= gf_next;
            b3_move_reg[k] <= b2_move_reg[k];
            b3_pin_reg[k]  <= b2_pin_reg[k];
            b3_vel_reg[k]  <= vel_next;
            pos_out_reg[k] <= pos_next;
            vel_out_reg[k] <= b3_vel_reg[k];
        end
    end

    assign done             = done_reg;
    assign result.new_pos_x = pos_out_reg[0];
    assign result.new_pos_y = pos_out_reg[1];
    assign result.new_pos_z = pos_out_reg[2];
    assign result.new_vel_x = vel_out_reg[0];
    assign result.new_vel_y = vel_out_reg[1];
    assign result.new_vel_z = vel_out_reg[2];

    `CNR_ASSERT_NXT(a_hold_pos_x, clk, rst_n, b3_vld_reg && !b3_move_reg[0], result.new_pos_x == $past(b3_pin_reg[0]))
    `CNR_ASSERT_IMP(a_done_from_ctx, clk, rst_n, done, $past(ctx_vld, 4))

endmodule

// ----- hdl/cable_net_node_relax_update_top.sv -----
// Dynamic-relaxation motion update for one cable-net node, Q19.12 throughout.
// Request channel: item carries class, position, velocity and force of one
// node; it is taken at a rising edge with start high and busy low. busy is
// never raised, so a new node can be taken at every edge.
// Result channel: done is high for exactly one cycle with the new position and
// velocity on result; the result is taken at the edge ending that cycle.
// Pipeline: three front stages, the 32-stage square root, two product stages,
// the 33-stage divider lanes and four update stages lie between the accepting
// edge and the edge taking the result.
// Throughput: one node per cycle, sustained.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// write only while no request is in flight.
// Reset: clears all valid bits and loads the register reset values; results
// in flight are dropped. The receiver cannot stall, so no result ever waits.
module cable_net_node_relax_update_top
    import cnr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  node_in_t    item,
    output logic        done,
    output node_out_t   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      accept;
    logic      front_vld;
    node_ctx_t front_ctx;
    logic      root_vld;
    node_ctx_t root_ctx;
    logic      div_vld;
    node_ctx_t div_ctx;
    quot_set_t div_quot;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.circle_radius <= 31'd7987200;
            cfg_reg.rim_height    <= 32'sd0;
            cfg_reg.damping       <= 16'd32440;
            cfg_reg.movement_gain <= 16'd32768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CIRCLE_RADIUS: cfg_reg.circle_radius <= cfg_data[30:0];
                CFG_RIM_HEIGHT:    cfg_reg.rim_height    <= cfg_data;
                CFG_DAMPING:       cfg_reg.damping       <= cfg_data[15:0];
                CFG_MOVEMENT_GAIN: cfg_reg.movement_gain <= cfg_data[15:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // request handshake
    assign busy   = 1'b0;
    assign accept = start && !busy;

    cnr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .ctx_vld (front_vld),
        .ctx     (front_ctx)
    );

    cnr_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (front_vld),
        .ctx_in  (front_ctx),
        .vld_out (root_vld),
        .ctx_out (root_ctx)
    );

    cnr_divide u_divide (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .vld_in  (root_vld),
        .ctx_in  (root_ctx),
        .vld_out (div_vld),
        .ctx_out (div_ctx),
        .quot    (div_quot)
    );

    cnr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .ctx_vld (div_vld),
        .ctx     (div_ctx),
        .quot    (div_quot),
        .done    (done),
        .result  (result)
    );

endmodule

// ----- sim/tb.sv -----
module tb;
    import cnr_pkg::*;

    typedef logic signed [127:0] wide_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    node_in_t    item;
    logic        done;
    node_out_t   result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // register copies used by the predictor
    logic [30:0]        cur_radius;
    logic signed [31:0] cur_height;
    logic [15:0]        cur_damp;
    logic [15:0]        cur_gain;

    node_out_t pending_updates[$];
    int        errors;
    bit        no_gaps;

    cable_net_node_relax_update_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #30000000;
        $display("tb: failure");
        $finish;
    end

    function automatic wide_t clamp32(wide_t v);
        if (v > 128'sd2147483647)
            return 128'sd2147483647;
        if (v < -128'sd2147483648)
            return -128'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // drop the component of (ax, ay) along the position vector
    function automatic void strip_radial(input wide_t px, input wide_t py, input wide_t r2,
                                         inout wide_t ax, inout wide_t ay);
        wide_t dot;
        dot = px * ax + py * ay;
        if (dot != 0)
        begin
            ax = ax - (dot * px) / r2;
            ay = ay - (dot * py) / r2;
        end
    endfunction

    // new position and velocity of one node
    function automatic node_out_t relax_node(node_in_t n);
        wide_t     p[3];
        wide_t     v[3];
        wide_t     f[3];
        bit        mv[3];
        wide_t     r2;
        wide_t     root;
        wide_t     rad;
        wide_t     dmp;
        wide_t     gn;
        wide_t     s;
        node_out_t o;
        p[0] = n.pos_x;   p[1] = n.pos_y;   p[2] = n.pos_z;
        v[0] = n.vel_x;   v[1] = n.vel_y;   v[2] = n.vel_z;
        f[0] = n.force_x; f[1] = n.force_y; f[2] = n.force_z;
        mv[0] = 0; mv[1] = 0; mv[2] = 0;
        rad = cur_radius;
        dmp = cur_damp;
        gn  = cur_gain;
        case (n.node_class)
            CLS_FREE:
            begin
                mv[0] = 1; mv[1] = 1; mv[2] = 1;
            end
            CLS_RIM:
            begin
                r2 = p[0] * p[0] + p[1] * p[1];
                if (r2 != 0)
                begin
                    root = root_floor(r2[63:0]);
                    strip_radial(p[0], p[1], r2, f[0], f[1]);
                    strip_radial(p[0], p[1], r2, v[0], v[1]);
                    p[0] = (p[0] * rad) / root;
                    p[1] = (p[1] * rad) / root;
                    f[2] = 0;
                    v[2] = 0;
                    p[2] = cur_height;
                    mv[0] = 1; mv[1] = 1; mv[2] = 1;
                end
            end
            CLS_SLIDE_X: mv[0] = 1;
            CLS_SLIDE_Y: mv[1] = 1;
            default: ;
        endcase
        for (int k = 0; k < 3; k++)
        begin
            if (mv[k])
            begin
                s    = dmp * v[k] + gn * f[k];
                v[k] = clamp32((s + 16384) >>> 15);
                p[k] = clamp32(p[k] + v[k]);
            end
        end
        o.new_pos_x = p[0][31:0];
        o.new_pos_y = p[1][31:0];
        o.new_pos_z = p[2][31:0];
        o.new_vel_x = v[0][31:0];
        o.new_vel_y = v[1][31:0];
        o.new_vel_z = v[2][31:0];
        return o;
    endfunction

    // predict on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            pending_updates.push_back(relax_node(item));
    end

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
        errors++;
    endtask

    // compare each result with the oldest prediction
    always @(posedge clk)
    begin
        node_out_t want;
        if (rst_n && done)
        begin
            if (pending_updates.size() == 0)
            begin
                report_mismatch("unexpected result", 32'h0, result.new_pos_x);
            end
            else
            begin
                want = pending_updates.pop_front();
                if (result.new_pos_x !== want.new_pos_x)
                    report_mismatch("new_pos_x", want.new_pos_x, result.new_pos_x);
                if (result.new_pos_y !== want.new_pos_y)
                    report_mismatch("new_pos_y", want.new_pos_y, result.new_pos_y);
                if (result.new_pos_z !== want.new_pos_z)
                    report_mismatch("new_pos_z", want.new_pos_z, result.new_pos_z);
                if (result.new_vel_x !== want.new_vel_x)
                    report_mismatch("new_vel_x", want.new_vel_x, result.new_vel_x);
                if (result.new_vel_y !== want.new_vel_y)
                    report_mismatch("new_vel_y", want.new_vel_y, result.new_vel_y);
                if (result.new_vel_z !== want.new_vel_z)
                    report_mismatch("new_vel_z", want.new_vel_z, result.new_vel_z);
            end
        end
    end

    // send one request; returns just after the accepting edge
    task automatic send_node(node_in_t n);
        item  <= n;
        start <= 1'b1;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    // random idle time between requests
    task automatic idle_gap();
        int n;
        n = 0;
        if (!no_gaps && $urandom_range(0, 9) >= 6)
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 90);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // stop sending and let every pending result come back
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_updates.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CIRCLE_RADIUS: cur_radius = val[30:0];
            CFG_RIM_HEIGHT:    cur_height = val;
            CFG_DAMPING:       cur_damp   = val[15:0];
            CFG_MOVEMENT_GAIN: cur_gain   = val[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3, 4: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic node_in_t rand_node();
        node_in_t n;
        int       c;
        c = $urandom_range(0, 19);
        if (c < 4)
            n.node_class = CLS_FREE;
        else if (c < 11)
            n.node_class = CLS_RIM;
        else if (c < 13)
            n.node_class = CLS_SLIDE_X;
        else if (c < 15)
            n.node_class = CLS_SLIDE_Y;
        else
            n.node_class = 3'($urandom_range(0, 7));
        n.pos_x   = rand_word();
        n.pos_y   = rand_word();
        n.pos_z   = rand_word();
        n.vel_x   = rand_word();
        n.vel_y   = rand_word();
        n.vel_z   = rand_word();
        n.force_x = rand_word();
        n.force_y = rand_word();
        n.force_z = rand_word();
        // a few rim nodes sit at the origin
        if (n.node_class == CLS_RIM && $urandom_range(0, 19) == 0)
        begin
            n.pos_x = 0;
            n.pos_y = 0;
        end
        return n;
    endfunction

    function automatic node_in_t make_node(logic [2:0] cls, logic [31:0] p, logic [31:0] v,
                                           logic [31:0] f);
        node_in_t n;
        n.node_class = cls;
        n.pos_x = p; n.pos_y = p + 32'd4096; n.pos_z = p;
        n.vel_x = v; n.vel_y = v;            n.vel_z = v;
        n.force_x = f; n.force_y = f;        n.force_z = f;
        return n;
    endfunction

    // every class, reset register values
    task automatic test_classes();
        for (int c = 0; c < 8; c++)
        begin
            send_node(make_node(3'(c), 32'h0001_0000, 32'h0000_2000, 32'hffff_f000));
            idle_gap();
        end
        drain();
    endtask

    // field extremes, rim at origin, saturation
    task automatic test_extremes();
        node_in_t n;
        send_node(make_node(CLS_FREE, 32'h7fff_f000, 32'h7fffffff, 32'h7fffffff));
        send_node(make_node(CLS_FREE, 32'h8000_0000, 32'h80000000, 32'h80000000));
        send_node(make_node(CLS_RIM, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
        send_node(make_node(CLS_RIM, 32'h80000000, 32'h80000000, 32'h7fffffff));
        n = make_node(CLS_RIM, 32'h0, 32'h1234, 32'h5678);
        n.pos_y = 0;
        send_node(n);
        send_node(make_node(CLS_SLIDE_X, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_node(make_node(CLS_SLIDE_Y, 32'h80000000, 32'h80000000, 32'h80000000));
        send_node(make_node(CLS_HELD, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        send_node(make_node(CLS_REMOVED, 32'h55555555, 32'haaaaaaaa, 32'h0));
        drain();
    endtask

    // register settings including the extremes
    task automatic test_settings();
        logic [31:0] radii[4];
        logic [31:0] heights[4];
        logic [31:0] gains[4];
        radii   = '{32'h0, 32'h7fffffff, 32'd4096, 32'd7987200};
        heights = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hfff0_0000};
        gains   = '{32'h0, 32'hffff, 32'd32768, 32'd32440};
        for (int s = 0; s < 4; s++)
        begin
            write_reg(CFG_CIRCLE_RADIUS, radii[s]);
            write_reg(CFG_RIM_HEIGHT, heights[s]);
            write_reg(CFG_DAMPING, gains[(s + 1) % 4]);
            write_reg(CFG_MOVEMENT_GAIN, gains[s]);
            for (int i = 0; i < 60; i++)
            begin
                send_node(rand_node());
                idle_gap();
            end
            drain();
        end
    endtask

    // long random stream, with a back-to-back stretch
    task automatic test_random();
        write_reg(CFG_CIRCLE_RADIUS, $urandom >> 1);
        write_reg(CFG_RIM_HEIGHT, $urandom);
        write_reg(CFG_DAMPING, $urandom_range(0, 65535));
        write_reg(CFG_MOVEMENT_GAIN, $urandom_range(0, 65535));
        for (int i = 0; i < 580; i++)
        begin
            no_gaps = (i >= 200 && i < 320);
            send_node(rand_node());
            idle_gap();
            // sender waits out all pending results now and then
            if (i % 150 == 149)
                drain();
        end
        no_gaps = 0;
        drain();
    endtask

    // main sequence
    initial
    begin
        int guard;
        errors    = 0;
        no_gaps   = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_CIRCLE_RADIUS;
        cfg_data  = 32'h0;
        cur_radius = 31'd7987200;
        cur_height = 32'sd0;
        cur_damp   = 16'd32440;
        cur_gain   = 16'd32768;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_classes();
        test_extremes();
        test_settings();
        test_random();
        start <= 1'b0;
        guard = 0;
        while (pending_updates.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_updates.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cnr_pkg.sv
hdl/cnr_front.sv
hdl/cnr_isqrt.sv
hdl/cnr_divide.sv
hdl/cnr_back.sv
hdl/cable_net_node_relax_update_top.sv
sim/tb.sv
